/* rtl/core/rmq_pkg.sv */
// Shared constants, widths and payload types of the rotation-matrix to
// quaternion pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC       = DATA_WIDTH - 2;
  // Magnitudes are pre-shifted so the norm datapath stays narrow
  localparam int SH         = (DATA_WIDTH > 16) ? (DATA_WIDTH - 16) : 0;
  localparam int VW         = DATA_WIDTH + 3;      // branch vector entries
  localparam int MW         = DATA_WIDTH + 1 - SH; // shifted magnitudes
  localparam int SQW        = 2 * MW;              // one square
  localparam int SW         = 2 * MW + 2;          // sum of four squares
  localparam int NW         = MW + 9;              // root of (sum << 16)
  localparam int XW         = 2 * NW;              // root radicand
  localparam int RW         = NW + 1;              // divider remainder
  localparam int QW         = DATA_WIDTH;          // quotient bits
  localparam int DVW        = MW + FRAC + 9;       // dividend

  localparam logic signed [DATA_WIDTH-1:0] ONE_Q =
    {{(DATA_WIDTH-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

  typedef logic signed [DATA_WIDTH-1:0] rmq_elem_t;

  typedef struct packed {
    rmq_elem_t r00; rmq_elem_t r01; rmq_elem_t r02;
    rmq_elem_t r10; rmq_elem_t r11; rmq_elem_t r12;
    rmq_elem_t r20; rmq_elem_t r21; rmq_elem_t r22;
  } rmq_mat_t;

  typedef struct packed {
    logic       degen;
    logic [3:0] sgn;
  } rmq_flag_t;

  typedef struct packed {
    rmq_flag_t          flag;
    logic [3:0][MW-1:0] mag;
  } rmq_side_t;

endpackage
`default_nettype wire

/* rtl/core/rmq_if.sv */
// Valid/ready channel interfaces for matrix input and quaternion result.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rmq_in_if;
  import rmq_pkg::*;
  logic      valid;
  logic      ready;
  rmq_elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic      valid;
  logic      ready;
  rmq_elem_t quat_w, quat_x, quat_y, quat_z;
  logic      degenerate;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Top level: rotation matrix (Q2.14) to unit quaternion, Shepperd's method.
// Depends on rmq_pkg, rmq_if, rmq_front, rmq_sqrt and rmq_div.
//
// Usage:
//   in_ch  (rmq_in_if.sink): nine signed matrix entries r00..r22, one matrix
//          per transfer.
//   out_ch (rmq_out_if.source): quat_w/x/y/z in Q2.14 and a degenerate flag
//          that marks a forced identity (non-positive radicand, zero norm).
//   From input to output transfer a matrix passes the front end, the
//   bit-per-stage square root, the bit-per-stage four-lane divider and the
//   output register.
//   Throughput is one matrix per cycle while out_ch.ready is high.
//   The whole pipeline advances on one enable. When the receiver holds off
//   with a result waiting, every stage freezes and in_ch.ready drops, so
//   nothing is lost or repeated; bubbles in the stream do not stall it.
//   Reset (rst_n low, synchronous) clears every stage valid bit; the
//   block keeps no other state.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmq_in_if.sink     in_ch,
  rmq_out_if.source  out_ch
);
  import rmq_pkg::*;

  logic      en;
  rmq_mat_t  mat;
  logic      fr_vld, sq_vld, dv_vld;
  rmq_side_t fr_side, sq_side;
  logic [XW-1:0] fr_x;
  logic [NW-1:0] sq_n;
  rmq_flag_t     dv_flag;
  logic [3:0][QW-1:0] dv_q;

  logic                  out_vld_r;
  logic [3:0][DATA_WIDTH-1:0] out_q_r, out_q_nxt;
  logic                  out_deg_r;

  // global pipeline advance
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  assign mat = '{r00: in_ch.r00, r01: in_ch.r01, r02: in_ch.r02,
                 r10: in_ch.r10, r11: in_ch.r11, r12: in_ch.r12,
                 r20: in_ch.r20, r21: in_ch.r21, r22: in_ch.r22};

  rmq_front u_front (
    .clk, .rst_n, .en,
    .vld_in   (in_ch.valid),
    .mat_in   (mat),
    .vld_out  (fr_vld),
    .side_out (fr_side),
    .x_out    (fr_x)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .vld_in   (fr_vld),
    .side_in  (fr_side),
    .x_in     (fr_x),
    .vld_out  (sq_vld),
    .side_out (sq_side),
    .root_out (sq_n)
  );

  rmq_div u_div (
    .clk, .rst_n, .en,
    .vld_in   (sq_vld),
    .side_in  (sq_side),
    .n_in     (sq_n),
    .vld_out  (dv_vld),
    .flag_out (dv_flag),
    .q_out    (dv_q)
  );

  // sign restore, identity on degenerate input
  always_comb begin
    logic [DATA_WIDTH-1:0] q;
    for (int k = 0; k < 4; k++) begin
      q = DATA_WIDTH'(dv_q[k]);
      out_q_nxt[k] = dv_flag.sgn[k] ? (-q) : q;
    end
    if (dv_flag.degen) begin
      out_q_nxt[0] = ONE_Q;
      out_q_nxt[1] = '0;
      out_q_nxt[2] = '0;
      out_q_nxt[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q_r   <= out_q_nxt;
      out_deg_r <= dv_flag.degen;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.quat_w     = out_q_r[0];
  assign out_ch.quat_x     = out_q_r[1];
  assign out_ch.quat_y     = out_q_r[2];
  assign out_ch.quat_z     = out_q_r[3];
  assign out_ch.degenerate = out_deg_r;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while pipeline frozen");

  a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_deg_r) |-> (out_q_r[0] == ONE_Q && out_q_r[1] == '0 &&
                                  out_q_r[2] == '0 && out_q_r[3] == '0))
    else $error("degenerate result is not identity");

  a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ($signed(out_q_r[0]) <= ONE_Q && $signed(out_q_r[0]) >= -ONE_Q))
    else $error("quat_w out of unit range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

/* rtl/core/rmq_front.sv */
// Front end: branch select, branch vector, magnitudes, squares and norm sum.
// Four register stages. Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_in,
  input  wire rmq_pkg::rmq_mat_t     mat_in,
  output logic                       vld_out,
  output rmq_pkg::rmq_side_t         side_out,
  output logic [rmq_pkg::XW-1:0]     x_out
);
  import rmq_pkg::*;

  localparam logic signed [VW-1:0] OneV = {{(VW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

  // stage 1: branch vector
  logic                        s1_vld_r, s1_vld_nxt;
  logic signed [3:0][VW-1:0]   s1_v_r, s1_v_nxt;
  logic                        s1_apos_r, s1_apos_nxt;
  // stage 2: magnitudes
  logic                        s2_vld_r;
  rmq_side_t                   s2_side_r, s2_side_nxt;
  // stage 3: squares
  logic                        s3_vld_r;
  rmq_side_t                   s3_side_r;
  logic [3:0][SQW-1:0]         s3_sq_r, s3_sq_nxt;
  // stage 4: norm
  logic                        s4_vld_r;
  rmq_side_t                   s4_side_r, s4_side_nxt;
  logic [XW-1:0]               s4_x_r, s4_x_nxt;

  // Shepperd branch selection and vector forming
  always_comb begin
    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, t, a;
    e00 = VW'(mat_in.r00); e01 = VW'(mat_in.r01); e02 = VW'(mat_in.r02);
    e10 = VW'(mat_in.r10); e11 = VW'(mat_in.r11); e12 = VW'(mat_in.r12);
    e20 = VW'(mat_in.r20); e21 = VW'(mat_in.r21); e22 = VW'(mat_in.r22);
    t = e00 + e11 + e22;
    s1_vld_nxt = vld_in;
    priority if (t > 0) begin
      a = OneV + t;
      s1_v_nxt[0] = a;         s1_v_nxt[1] = e21 - e12;
      s1_v_nxt[2] = e02 - e20; s1_v_nxt[3] = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      a = OneV + e00 - e11 - e22;
      s1_v_nxt[0] = e21 - e12; s1_v_nxt[1] = a;
      s1_v_nxt[2] = e01 + e10; s1_v_nxt[3] = e02 + e20;
    end else if (e11 > e22) begin
      a = OneV + e11 - e00 - e22;
      s1_v_nxt[0] = e02 - e20; s1_v_nxt[1] = e01 + e10;
      s1_v_nxt[2] = a;         s1_v_nxt[3] = e12 + e21;
    end else begin
      a = OneV + e22 - e00 - e11;
      s1_v_nxt[0] = e10 - e01; s1_v_nxt[1] = e02 + e20;
      s1_v_nxt[2] = e12 + e21; s1_v_nxt[3] = a;
    end
    s1_apos_nxt = (a > 0);
  end

  // magnitudes and signs
  always_comb begin
    logic signed [VW-1:0] av;
    logic [VW-1:0]        sh;
    s2_side_nxt.flag.degen = !s1_apos_r;
    for (int k = 0; k < 4; k++) begin
      av = s1_v_r[k][VW-1] ? -s1_v_r[k] : s1_v_r[k];
      sh = VW'(av) >> SH;
      s2_side_nxt.mag[k]      = sh[MW-1:0];
      s2_side_nxt.flag.sgn[k] = s1_v_r[k][VW-1];
    end
  end

  // squares
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s3_sq_nxt[k] = SQW'(s2_side_r.mag[k]) * SQW'(s2_side_r.mag[k]);
    end
  end

  // norm sum, scaled by 2^16 for the root
  always_comb begin
    logic [SW-1:0] nsq;
    nsq = SW'(s3_sq_r[0]) + SW'(s3_sq_r[1]) + SW'(s3_sq_r[2]) + SW'(s3_sq_r[3]);
    s4_x_nxt    = {nsq, 16'b0};
    s4_side_nxt = s3_side_r;
    s4_side_nxt.flag.degen = s3_side_r.flag.degen || (nsq == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v_r    <= s1_v_nxt;
      s1_apos_r <= s1_apos_nxt;
      s2_side_r <= s2_side_nxt;
      s3_side_r <= s2_side_r;
      s3_sq_r   <= s3_sq_nxt;
      s4_side_r <= s4_side_nxt;
      s4_x_r    <= s4_x_nxt;
    end
  end

  assign vld_out  = s4_vld_r;
  assign side_out = s4_side_r;
  assign x_out    = s4_x_r;

endmodule
`default_nettype wire

/* rtl/core/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per stage (NW stages).
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_in,
  input  wire rmq_pkg::rmq_side_t    side_in,
  input  wire logic [rmq_pkg::XW-1:0] x_in,
  output logic                       vld_out,
  output rmq_pkg::rmq_side_t         side_out,
  output logic [rmq_pkg::NW-1:0]     root_out
);
  import rmq_pkg::*;

  logic            vld_r  [NW];
  rmq_side_t       side_r [NW];
  logic [XW-1:0]   x_r    [NW];
  logic [NW+1:0]   rem_r  [NW];
  logic [NW-1:0]   root_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          vld_src;
    rmq_side_t     side_src;
    logic [XW-1:0] x_src;
    logic [NW+1:0] rem_src, rem_sh, trial, rem_nxt;
    logic [NW-1:0] root_src, root_nxt;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_src  = vld_in;
      assign side_src = side_in;
      assign x_src    = x_in;
      assign rem_src  = '0;
      assign root_src = '0;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign side_src = side_r[k-1];
      assign x_src    = x_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign root_src = root_r[k-1];
    end

    // one digit: bring in two radicand bits, try (4*root + 1)
    always_comb begin
      rem_sh   = {rem_src[NW-1:0], x_src[XW-1 -: 2]};
      trial    = {root_src, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_src[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_src;
        x_r[k]    <= {x_src[XW-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign vld_out  = vld_r[NW-1];
  assign side_out = side_r[NW-1];
  assign root_out = root_r[NW-1];

endmodule
`default_nettype wire

/* rtl/core/rmq_div.sv */
// Four-lane pipelined restoring divider, rounded quotients of each
// magnitude by the norm root. One prep stage then QW stages. Uses rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   vld_in,
  input  wire rmq_pkg::rmq_side_t     side_in,
  input  wire logic [rmq_pkg::NW-1:0] n_in,
  output logic                        vld_out,
  output rmq_pkg::rmq_flag_t          flag_out,
  output logic [3:0][rmq_pkg::QW-1:0] q_out
);
  import rmq_pkg::*;

  // prep: dividend = mag << (FRAC+8) plus half the divisor
  logic                 pv_r;
  rmq_flag_t            pflag_r;
  logic [NW-1:0]        pn_r;
  logic [3:0][RW-1:0]   prem_r, prem_nxt;
  logic [3:0][QW-1:0]   pdq_r, pdq_nxt;

  always_comb begin
    logic [DVW-1:0] dvd;
    for (int l = 0; l < 4; l++) begin
      dvd = (DVW'(side_in.mag[l]) << (FRAC + 8)) + DVW'(n_in >> 1);
      prem_nxt[l] = RW'(dvd >> QW);
      pdq_nxt[l]  = dvd[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pflag_r <= side_in.flag;
      pn_r    <= n_in;
      prem_r  <= prem_nxt;
      pdq_r   <= pdq_nxt;
    end
  end

  logic               vld_r  [QW];
  rmq_flag_t          flag_r [QW];
  logic [NW-1:0]      n_r    [QW];
  logic [3:0][RW-1:0] rem_r  [QW];
  logic [3:0][QW-1:0] dq_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic               vld_src;
    rmq_flag_t          flag_src;
    logic [NW-1:0]      n_src;
    logic [3:0][RW-1:0] rem_src, rem_nxt;
    logic [3:0][QW-1:0] dq_src, dq_nxt;

    if (k == 0) begin : g_first
      assign vld_src  = pv_r;
      assign flag_src = pflag_r;
      assign n_src    = pn_r;
      assign rem_src  = prem_r;
      assign dq_src   = pdq_r;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign flag_src = flag_r[k-1];
      assign n_src    = n_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign dq_src   = dq_r[k-1];
    end

    // one quotient bit per lane; quotient bits shift in as dividend shifts out
    always_comb begin
      logic [RW-1:0] sh;
      logic          ge;
      for (int l = 0; l < 4; l++) begin
        sh         = {rem_src[l][RW-2:0], dq_src[l][QW-1]};
        ge         = (sh >= RW'(n_src));
        rem_nxt[l] = ge ? (sh - RW'(n_src)) : sh;
        dq_nxt[l]  = {dq_src[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flag_r[k] <= flag_src;
        n_r[k]    <= n_src;
        rem_r[k]  <= rem_nxt;
        dq_r[k]   <= dq_nxt;
      end
    end
  end

  assign vld_out  = vld_r[QW-1];
  assign flag_out = flag_r[QW-1];
  assign q_out    = dq_r[QW-1];

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for rotation_matrix_to_quaternion: matrix transfers in,
// quaternion transfers out, each checked against a local fixed-point predictor.
// Depends on rmq_pkg, rmq_if and the RTL of the block.
`timescale 1ns / 1ps
module tb;
  import rmq_pkg::*;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] w, x, y, z;
    logic                         degen;
  } quat_t;

  localparam int LATENCY   = 48;
  localparam int MAX_CYCLES = 200000;

  logic clk;
  logic rst_n;
  int   cycles;
  int   errors;
  int   sent;
  int   got;
  int   degen_seen;
  quat_t quat_q[$];

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Integer square root, bit by bit
  function automatic longint unsigned isqrt(input longint unsigned val);
    longint unsigned res, bit_v, x;
    res = 0;
    x = val;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Shepperd branch choice, then normalisation of the scaled vector
  function automatic quat_t shepperd_quat(input rmq_mat_t m);
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, rad, one;
    longint v[4];
    longint unsigned mag[4], nsq, n, q;
    quat_t r;
    one = longint'(1) << FRAC;
    m00 = longint'(m.r00); m01 = longint'(m.r01); m02 = longint'(m.r02);
    m10 = longint'(m.r10); m11 = longint'(m.r11); m12 = longint'(m.r12);
    m20 = longint'(m.r20); m21 = longint'(m.r21); m22 = longint'(m.r22);
    tr = m00 + m11 + m22;
    if (tr > 0) begin
      rad = one + tr;
      v[0] = rad; v[1] = m21 - m12; v[2] = m02 - m20; v[3] = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      rad = one + m00 - m11 - m22;
      v[0] = m21 - m12; v[1] = rad; v[2] = m01 + m10; v[3] = m02 + m20;
    end else if (m11 > m22) begin
      rad = one + m11 - m00 - m22;
      v[0] = m02 - m20; v[1] = m01 + m10; v[2] = rad; v[3] = m12 + m21;
    end else begin
      rad = one + m22 - m00 - m11;
      v[0] = m10 - m01; v[1] = m02 + m20; v[2] = m12 + m21; v[3] = rad;
    end
    nsq = 0;
    if (rad > 0) begin
      for (int k = 0; k < 4; k++) begin
        mag[k] = longint'(v[k] < 0 ? -v[k] : v[k]) >> SH;
        nsq += mag[k] * mag[k];
      end
    end
    if (rad <= 0 || nsq == 0) begin
      r.w = ONE_Q; r.x = '0; r.y = '0; r.z = '0; r.degen = 1'b1;
      return r;
    end
    n = isqrt(nsq << 16);
    for (int k = 0; k < 4; k++) begin
      q = (mag[k] * longint'(one) * 256 + (n >> 1)) / n;
      if (v[k] < 0) q = -q;
      case (k)
        0: r.w = q[DATA_WIDTH-1:0];
        1: r.x = q[DATA_WIDTH-1:0];
        2: r.y = q[DATA_WIDTH-1:0];
        default: r.z = q[DATA_WIDTH-1:0];
      endcase
    end
    r.degen = 1'b0;
    return r;
  endfunction

  // Send one matrix with a random lead-in gap
  task automatic send_matrix(input rmq_mat_t m);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.r00 <= m.r00; in_ch.r01 <= m.r01; in_ch.r02 <= m.r02;
    in_ch.r10 <= m.r10; in_ch.r11 <= m.r11; in_ch.r12 <= m.r12;
    in_ch.r20 <= m.r20; in_ch.r21 <= m.r21; in_ch.r22 <= m.r22;
    do @(posedge clk); while (!in_ch.ready);
    quat_q = {quat_q, shepperd_quat(m)};
    sent++;
    @(negedge clk);
  endtask

  function automatic rmq_mat_t rand_mat();
    rmq_mat_t   m;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    m = raw[$bits(rmq_mat_t)-1:0];
    return m;
  endfunction

  // Near-rotation: signed permutation with small perturbations
  function automatic rmq_mat_t perm_mat();
    rmq_mat_t m;
    rmq_elem_t e[9];
    int p, sg, dev;
    p = $urandom_range(0, 5);
    for (int i = 0; i < 9; i++) e[i] = rmq_elem_t'($urandom_range(0, 600) - 300);
    for (int r = 0; r < 3; r++) begin
      int c;
      c = (r + p) % 3;
      if (p >= 3) c = (3 - r + p) % 3;
      sg = $urandom_range(0, 1);
      dev = $urandom_range(0, 2000);
      e[r*3+c] = rmq_elem_t'(sg ? dev - 16384 : 16384 - dev);
    end
    m.r00 = e[0]; m.r01 = e[1]; m.r02 = e[2];
    m.r10 = e[3]; m.r11 = e[4]; m.r12 = e[5];
    m.r20 = e[6]; m.r21 = e[7]; m.r22 = e[8];
    return m;
  endfunction

  function automatic rmq_mat_t diag_mat(input int a, b, c);
    rmq_mat_t m;
    m = '0;
    m.r00 = rmq_elem_t'(a); m.r11 = rmq_elem_t'(b); m.r22 = rmq_elem_t'(c);
    return m;
  endfunction

  // Result side: random stalls, check against oldest expectation
  initial begin
    int stall;
    quat_t e;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got++;
        if (quat_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          e = quat_q.pop_front();
          if (e.degen) degen_seen++;
          if (out_ch.quat_w !== e.w) begin
            $error("quat_w expected %0d got %0d", e.w, out_ch.quat_w); errors++;
          end
          if (out_ch.quat_x !== e.x) begin
            $error("quat_x expected %0d got %0d", e.x, out_ch.quat_x); errors++;
          end
          if (out_ch.quat_y !== e.y) begin
            $error("quat_y expected %0d got %0d", e.y, out_ch.quat_y); errors++;
          end
          if (out_ch.quat_z !== e.z) begin
            $error("quat_z expected %0d got %0d", e.z, out_ch.quat_z); errors++;
          end
          if (out_ch.degenerate !== e.degen) begin
            $error("degenerate expected %0d got %0d", e.degen, out_ch.degenerate);
            errors++;
          end
        end
        stall = $urandom_range(0, 4);
        if (cycles > 40000 && cycles < 42000) stall = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_identity_and_signs();
    rmq_mat_t m;
    send_matrix(diag_mat(16384, 16384, 16384));
    send_matrix(diag_mat(16384, -16384, -16384));
    send_matrix(diag_mat(-16384, 16384, -16384));
    send_matrix(diag_mat(-16384, -16384, 16384));
    m = perm_mat(); send_matrix(m);
  endtask

  task automatic test_extremes();
    rmq_mat_t m;
    m = '0; send_matrix(m);                       // trace zero, ties to r22
    m = '1; send_matrix(m);                       // all -1
    send_matrix(diag_mat(32767, 32767, 32767));
    send_matrix(diag_mat(-32768, -32768, -32768)); // r22 branch, radicand 3.0
    send_matrix(diag_mat(-16384, -16384, -16384)); // r22 branch, radicand 2.0
    send_matrix(diag_mat(32767, -32768, -32768));
    m = {9{16'sh8000}}; send_matrix(m);
    m = {9{16'sh7fff}}; send_matrix(m);
    m = {16'sh0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0, 16'sh7fff,
         16'sh7fff, 16'sh8000, 16'sh0};
    send_matrix(m);
    send_matrix(diag_mat(0, 5, 5));                // positive trace, w branch
    send_matrix(diag_mat(5, 5, -10));              // r11 branch via tie on r00
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) send_matrix(perm_mat());
      else send_matrix(rand_mat());
    end
  endtask

  initial begin
    int drain;
    errors = 0; sent = 0; got = 0; degen_seen = 0;
    in_ch.valid = 1'b0;
    {in_ch.r00, in_ch.r01, in_ch.r02, in_ch.r10, in_ch.r11, in_ch.r12,
     in_ch.r20, in_ch.r21, in_ch.r22} = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_identity_and_signs();
    test_extremes();
    test_random(750);
    in_ch.valid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 2 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    $display("summary: %0d matrices sent, %0d quaternions checked, %0d degenerate",
             sent, got, degen_seen);
    if (errors == 0 && quat_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
